// File: src/adbsm_pkg.sv
// adbsm_pkg: shared types and constants of the arcball drag sphere mapper
// no dependencies; used by adbsm_divsqrt, the top level and the checker
package adbsm_pkg;

  // register and result field widths
  localparam int REG_W  = 13;
  localparam int XY_W   = 16;
  localparam int Z_W    = 15;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // register reset values
  localparam logic [REG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [REG_W-1:0] HEIGHT_RESET = 13'd480;

  // register indexes, taken from paddr bit 2
  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  // event codes
  localparam logic [1:0] OP_MOVE    = 2'd0;
  localparam logic [1:0] OP_PRESS   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // button codes
  localparam logic [1:0] BTN_LEFT    = 2'd0;
  localparam logic [1:0] BTN_RIGHT   = 2'd1;
  localparam logic [1:0] BTN_MIDDLE  = 2'd2;
  localparam logic [1:0] BTN_UNKNOWN = 2'd3;

  // main sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQX,
    ST_SQY,
    ST_SQH,
    ST_SUM,
    ST_DX,
    ST_WX,
    ST_DY,
    ST_WY,
    ST_DZ,
    ST_WZ,
    ST_STORE,
    ST_OUT
  } seq_state_t;

  // divide and square root unit phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_SQRT,
    PH_DONE
  } dsu_phase_t;

endpackage

// File: src/arcball_drag_sphere_mapper.sv
// arcball_drag_sphere_mapper: pointer event decode, drag state and sphere point sequencer
// depends on adbsm_pkg and adbsm_divsqrt
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  in       | in_valid / in_stall       | operation, button, cursor_x, cursor_y
//  out      | out_valid / out_stall     | from_x, from_y, from_z, to_x, to_y, to_z
//  config   | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// an event with no result leaves in_stall low; a move that emits a transaction holds in_stall
// high while both points are mapped, with no z step for a rim point, and while it waits
// for the output register; the mapping is done by the one shared divide and square root unit,
// used up to six times in series
// rst is synchronous; width 640, height 480, drag off, last cursor at 0
// a finished transaction waits in the output register; the next event is taken meanwhile
module arcball_drag_sphere_mapper #(
  parameter int FRAC_BITS   = 14,
  parameter int CURSOR_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adbsm_pkg::APB_AW-1:0]        paddr,
  input  logic [adbsm_pkg::APB_DW-1:0]        pwdata,
  output logic [adbsm_pkg::APB_DW-1:0]        prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          operation,
  input  logic [1:0]                          button,
  input  logic signed [CURSOR_BITS-1:0]       cursor_x,
  input  logic signed [CURSOR_BITS-1:0]       cursor_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [adbsm_pkg::XY_W-1:0]   from_x,
  output logic signed [adbsm_pkg::XY_W-1:0]   from_y,
  output logic [adbsm_pkg::Z_W-1:0]           from_z,
  output logic signed [adbsm_pkg::XY_W-1:0]   to_x,
  output logic signed [adbsm_pkg::XY_W-1:0]   to_y,
  output logic [adbsm_pkg::Z_W-1:0]           to_z
);

  localparam int REG_W = adbsm_pkg::REG_W;
  localparam int XY_W  = adbsm_pkg::XY_W;
  localparam int Z_W   = adbsm_pkg::Z_W;
  localparam int NW    = ((CURSOR_BITS + 1 > REG_W + 1) ? CURSOR_BITS + 1 : REG_W + 1) + 1;
  localparam int AW    = NW - 1;
  localparam int SW    = 2 * AW;
  localparam int DW    = SW + 1;
  localparam int MW    = FRAC_BITS + 1;
  localparam int TW    = (MW > XY_W) ? MW + 1 : XY_W + 1;
  localparam int ZT    = (MW > Z_W) ? MW : Z_W;

  // configuration registers
  logic [REG_W-1:0] viewport_width;
  logic [REG_W-1:0] viewport_height;
  logic             cfg_wr;

  // event state
  logic                   drag_enabled;
  logic [CURSOR_BITS-1:0] last_x;
  logic [CURSOR_BITS-1:0] last_y;
  logic                   in_acc;
  logic                   emit;

  // sequencer
  adbsm_pkg::seq_state_t state, state_next;
  logic                   pt_sel;
  logic [CURSOR_BITS-1:0] pt0_x, pt0_y, pt1_x, pt1_y;
  logic [AW-1:0]          ax, ay;
  logic                   negx, negy;
  logic [SW-1:0]          sqx, sqy, h2;
  logic [DW-1:0]          ssum;
  logic                   rim;
  logic [MW-1:0]          mag_x, mag_y, mag_z;
  logic signed [XY_W-1:0] frm_x, frm_y;
  logic [Z_W-1:0]         frm_z;

  // combinational datapath
  logic [REG_W-1:0]       h_eff;
  logic [CURSOR_BITS-1:0] px, py;
  logic [NW-1:0]          px_ext, py_ext, nx, ny, nx_neg, ny_neg;
  logic [AW-1:0]          mul_a;
  logic [SW-1:0]          prod;
  logic [DW-1:0]          ssum_next, h2_ext, den_sel, dsu_num, dsu_den;
  logic                   dsu_start, dsu_done, load_out;
  logic [MW-1:0]          dsu_root;
  logic [TW-1:0]          xe, ye, xs, ys;
  logic [ZT-1:0]          ze;
  logic [XY_W-1:0]        x_val, y_val;
  logic [Z_W-1:0]         z_val;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[2])
      adbsm_pkg::REG_IDX_WIDTH:  prdata = adbsm_pkg::APB_DW'(viewport_width);
      adbsm_pkg::REG_IDX_HEIGHT: prdata = adbsm_pkg::APB_DW'(viewport_height);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_width  <= adbsm_pkg::WIDTH_RESET;
      viewport_height <= adbsm_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == adbsm_pkg::REG_IDX_WIDTH) viewport_width <= pwdata[REG_W-1:0];
      else viewport_height <= pwdata[REG_W-1:0];
    end
  end

  // event decode
  assign in_acc = in_valid & ~in_stall;
  assign emit   = in_acc & (operation == adbsm_pkg::OP_MOVE) & drag_enabled &
                  ((cursor_x != last_x) | (cursor_y != last_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_enabled <= 1'b0;
      last_x       <= '0;
      last_y       <= '0;
    end else if (in_acc && operation != adbsm_pkg::OP_IGNORED) begin
      last_x <= cursor_x;
      last_y <= cursor_y;
      if (operation == adbsm_pkg::OP_PRESS) drag_enabled <= button == adbsm_pkg::BTN_RIGHT;
      else if (operation == adbsm_pkg::OP_RELEASE) drag_enabled <= 1'b0;
    end
  end

  // centered coordinates of the current point
  always_comb begin
    h_eff  = (viewport_height == '0) ? REG_W'(1) : viewport_height;
    px     = pt_sel ? pt1_x : pt0_x;
    py     = pt_sel ? pt1_y : pt0_y;
    px_ext = {{(NW - CURSOR_BITS){px[CURSOR_BITS-1]}}, px};
    py_ext = {{(NW - CURSOR_BITS){py[CURSOR_BITS-1]}}, py};
    nx     = {px_ext[NW-2:0], 1'b0} - {{(NW - REG_W){1'b0}}, viewport_width};
    ny     = {{(NW - REG_W){1'b0}}, h_eff} - {py_ext[NW-2:0], 1'b0};
    nx_neg = '0 - nx;
    ny_neg = '0 - ny;
  end

  // shared squarer
  always_comb begin
    unique case (state)
      adbsm_pkg::ST_SQX: mul_a = ax;
      adbsm_pkg::ST_SQY: mul_a = ay;
      default:           mul_a = {{(AW - REG_W){1'b0}}, h_eff};
    endcase
    prod      = mul_a * mul_a;
    ssum_next = {1'b0, sqx} + {1'b0, sqy};
    h2_ext    = {1'b0, h2};
    den_sel   = rim ? ssum : h2_ext;
  end

  // operands of the divide and square root unit
  always_comb begin
    unique case (state)
      adbsm_pkg::ST_DX: begin
        dsu_num = {1'b0, sqx};
        dsu_den = den_sel;
      end
      adbsm_pkg::ST_DY: begin
        dsu_num = {1'b0, sqy};
        dsu_den = den_sel;
      end
      default: begin
        dsu_num = h2_ext - ssum;
        dsu_den = h2_ext;
      end
    endcase
  end

  adbsm_divsqrt #(
    .FRAC_BITS (FRAC_BITS),
    .DEN_W     (DW)
  ) u_dsu (
    .clk   (clk),
    .rst   (rst),
    .start (dsu_start),
    .num   (dsu_num),
    .den   (dsu_den),
    .done  (dsu_done),
    .root  (dsu_root)
  );

  // signed fields of the current point
  always_comb begin
    xe    = TW'(mag_x);
    ye    = TW'(mag_y);
    xs    = negx ? ('0 - xe) : xe;
    ys    = negy ? ('0 - ye) : ye;
    ze    = ZT'(mag_z);
    x_val = xs[XY_W-1:0];
    y_val = ys[XY_W-1:0];
    z_val = ze[Z_W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      adbsm_pkg::ST_IDLE:  if (emit) state_next = adbsm_pkg::ST_LOAD;
      adbsm_pkg::ST_LOAD:  state_next = adbsm_pkg::ST_SQX;
      adbsm_pkg::ST_SQX:   state_next = adbsm_pkg::ST_SQY;
      adbsm_pkg::ST_SQY:   state_next = adbsm_pkg::ST_SQH;
      adbsm_pkg::ST_SQH:   state_next = adbsm_pkg::ST_SUM;
      adbsm_pkg::ST_SUM:   state_next = adbsm_pkg::ST_DX;
      adbsm_pkg::ST_DX:    state_next = adbsm_pkg::ST_WX;
      adbsm_pkg::ST_WX:    if (dsu_done) state_next = adbsm_pkg::ST_DY;
      adbsm_pkg::ST_DY:    state_next = adbsm_pkg::ST_WY;
      adbsm_pkg::ST_WY: begin
        if (dsu_done) state_next = rim ? adbsm_pkg::ST_STORE : adbsm_pkg::ST_DZ;
      end
      adbsm_pkg::ST_DZ:    state_next = adbsm_pkg::ST_WZ;
      adbsm_pkg::ST_WZ:    if (dsu_done) state_next = adbsm_pkg::ST_STORE;
      adbsm_pkg::ST_STORE: state_next = pt_sel ? adbsm_pkg::ST_OUT : adbsm_pkg::ST_LOAD;
      adbsm_pkg::ST_OUT:   if (load_out) state_next = adbsm_pkg::ST_IDLE;
      default:             state_next = adbsm_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = state != adbsm_pkg::ST_IDLE;
    dsu_start = (state == adbsm_pkg::ST_DX) | (state == adbsm_pkg::ST_DY) |
                (state == adbsm_pkg::ST_DZ);
    load_out  = (state == adbsm_pkg::ST_OUT) & (~out_valid | ~out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= adbsm_pkg::ST_IDLE;
      pt_sel    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) pt_sel <= 1'b0;
      else if (state == adbsm_pkg::ST_STORE) pt_sel <= 1'b1;
      if (load_out) out_valid <= 1'b1;
      else if (~out_stall) out_valid <= 1'b0;
    end
  end

  // point datapath
  always_ff @(posedge clk) begin
    if (emit) begin
      pt0_x <= last_x;
      pt0_y <= last_y;
      pt1_x <= cursor_x;
      pt1_y <= cursor_y;
    end
    unique case (state)
      adbsm_pkg::ST_LOAD: begin
        negx <= nx[NW-1];
        negy <= ny[NW-1];
        ax   <= nx[NW-1] ? nx_neg[AW-1:0] : nx[AW-1:0];
        ay   <= ny[NW-1] ? ny_neg[AW-1:0] : ny[AW-1:0];
      end
      adbsm_pkg::ST_SQX: sqx <= prod;
      adbsm_pkg::ST_SQY: sqy <= prod;
      adbsm_pkg::ST_SQH: h2  <= prod;
      adbsm_pkg::ST_SUM: begin
        ssum  <= ssum_next;
        rim   <= ssum_next >= {1'b0, h2};
        mag_z <= '0;
      end
      adbsm_pkg::ST_WX: if (dsu_done) mag_x <= dsu_root;
      adbsm_pkg::ST_WY: if (dsu_done) mag_y <= dsu_root;
      adbsm_pkg::ST_WZ: if (dsu_done) mag_z <= dsu_root;
      adbsm_pkg::ST_STORE: begin
        if (!pt_sel) begin
          frm_x <= x_val;
          frm_y <= y_val;
          frm_z <= z_val;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      from_x <= frm_x;
      from_y <= frm_y;
      from_z <= frm_z;
      to_x   <= x_val;
      to_y   <= y_val;
      to_z   <= z_val;
    end
  end

endmodule

// File: src/adbsm_divsqrt.sv
// adbsm_divsqrt: shared iterative unit, isqrt(floor(num * 2^(2F) / den)) for num <= den
// one restoring quotient bit per cycle, then one root bit per cycle; uses adbsm_pkg
module adbsm_divsqrt #(
  parameter int FRAC_BITS = 14,
  parameter int DEN_W     = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DEN_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  output logic                 done,
  output logic [FRAC_BITS:0]   root
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int CW = $clog2(2 * FRAC_BITS + 1);

  adbsm_pkg::dsu_phase_t phase, phase_next;
  logic [CW-1:0]    cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [QW-1:0]    quo;
  logic [QW-1:0]    rad;
  logic [QW-1:0]    res;
  logic [QW-1:0]    bitm;

  logic [DEN_W:0]   rem2;
  logic [DEN_W:0]   rdiff;
  logic             rge;
  logic [QW-1:0]    quo_next;
  logic [QW:0]      trial;
  logic             take;
  logic             div_last;
  logic             sqrt_last;

  // one restoring division step
  always_comb begin
    rem2     = {rem, 1'b0};
    rdiff    = rem2 - {1'b0, dvs};
    rge      = rem2 >= {1'b0, dvs};
    quo_next = {quo[QW-2:0], rge};
  end

  // one root step
  always_comb begin
    trial = {1'b0, res} + {1'b0, bitm};
    take  = {1'b0, rad} >= trial;
  end

  assign div_last  = cnt == CW'(2 * FRAC_BITS - 1);
  assign sqrt_last = cnt == CW'(FRAC_BITS);

  // phase sequencing
  always_comb begin
    phase_next = phase;
    unique case (phase)
      adbsm_pkg::PH_IDLE: if (start) phase_next = adbsm_pkg::PH_DIV;
      adbsm_pkg::PH_DIV:  if (div_last) phase_next = adbsm_pkg::PH_SQRT;
      adbsm_pkg::PH_SQRT: if (sqrt_last) phase_next = adbsm_pkg::PH_DONE;
      adbsm_pkg::PH_DONE: phase_next = adbsm_pkg::PH_IDLE;
      default:            phase_next = adbsm_pkg::PH_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = phase == adbsm_pkg::PH_DONE;
    root = res[FRAC_BITS:0];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= adbsm_pkg::PH_IDLE;
      cnt   <= '0;
    end else begin
      phase <= phase_next;
      if (phase_next != phase) cnt <= '0;
      else cnt <= cnt + CW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (phase)
      adbsm_pkg::PH_IDLE: begin
        if (start) begin
          dvs <= den;
          // integer part is one only when num equals den
          if (num == den) begin
            quo <= QW'(1);
            rem <= '0;
          end else begin
            quo <= '0;
            rem <= num;
          end
        end
      end
      adbsm_pkg::PH_DIV: begin
        quo <= quo_next;
        rem <= rge ? rdiff[DEN_W-1:0] : rem2[DEN_W-1:0];
        if (div_last) begin
          rad  <= quo_next;
          res  <= '0;
          bitm <= QW'(1) << (2 * FRAC_BITS);
        end
      end
      adbsm_pkg::PH_SQRT: begin
        if (take) begin
          rad <= rad - trial[QW-1:0];
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/adbsm_checker.sv
// adbsm_props: port-level assertions of the arcball drag sphere mapper
// depends on adbsm_pkg; bound to arcball_drag_sphere_mapper below
module adbsm_props (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  operation,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [adbsm_pkg::XY_W-1:0]  from_x,
  input logic [adbsm_pkg::XY_W-1:0]  to_x
);

  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled transaction keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(from_x) && $stable(to_x))
    else $error("payload changed while stalled");

  // a non-move event (press, release or ignored) never produces a transaction right after it
  a_no_result_non_move: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation != adbsm_pkg::OP_MOVE |=> !$rose(out_valid))
    else $error("transaction after a non-move event");

  // a new transaction appears only as the block returns to taking events
  a_free_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("busy when a transaction appears");

  // reset leaves the output empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind arcball_drag_sphere_mapper adbsm_props u_adbsm_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .operation (operation),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .from_x    (from_x),
  .to_x      (to_x)
);

// File: dv/adbsm_checker.sv
// adbsm_checker: watches the event, result and register channels of the sphere mapper,
// predicts each result transaction and compares it field by field; depends on adbsm_pkg
module adbsm_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [adbsm_pkg::APB_AW-1:0]      paddr,
  input  logic [adbsm_pkg::APB_DW-1:0]      pwdata,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [1:0]                        button,
  input  logic signed [13:0]                cursor_x,
  input  logic signed [13:0]                cursor_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [15:0]                from_x,
  input  logic signed [15:0]                from_y,
  input  logic [14:0]                       from_z,
  input  logic signed [15:0]                to_x,
  input  logic signed [15:0]                to_y,
  input  logic [14:0]                       to_z,
  output int                                errors,
  output int                                pending
);

  localparam int FRAC = 14;

  typedef struct packed {
    logic [15:0] fx;
    logic [15:0] fy;
    logic [14:0] fz;
    logic [15:0] tx;
    logic [15:0] ty;
    logic [14:0] tz;
  } drag_pair_t;

  drag_pair_t pair_q[$];
  logic [adbsm_pkg::REG_W-1:0] vp_w, vp_h;
  logic             dragging;
  logic [13:0]      prev_x, prev_y;

  assign pending = pair_q.size();

  // floor(num * 2^(2*FRAC) / den), num <= den
  function automatic longint unsigned scaled_ratio(longint unsigned num,
                                                    longint unsigned den);
    return (num << (2 * FRAC)) / den;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // map one cursor onto the arcball sphere
  function automatic logic [46:0] sphere_of(logic signed [13:0] px, logic signed [13:0] py);
    longint nx, ny, hh;
    longint unsigned ax, ay, s, h2, den, zz, mx, my;
    logic [15:0] ox, oy;
    hh = (vp_h == 0) ? 1 : longint'(vp_h);
    nx = 2 * longint'(px) - longint'(vp_w);
    ny = hh - 2 * longint'(py);
    ax = (nx < 0) ? -nx : nx;
    ay = (ny < 0) ? -ny : ny;
    s = ax * ax + ay * ay;
    h2 = hh * hh;
    if (s >= h2) begin
      den = s;
      zz = 0;
    end else begin
      den = h2;
      zz = int_sqrt(scaled_ratio(h2 - s, h2));
    end
    mx = int_sqrt(scaled_ratio(ax * ax, den));
    my = int_sqrt(scaled_ratio(ay * ay, den));
    ox = (nx < 0) ? 16'(-mx) : 16'(mx);
    oy = (ny < 0) ? 16'(-my) : 16'(my);
    return {ox, oy, 15'(zz)};
  endfunction

  // register writes
  always @(posedge clk) begin
    if (rst) begin
      vp_w <= adbsm_pkg::WIDTH_RESET;
      vp_h <= adbsm_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == adbsm_pkg::REG_IDX_WIDTH) vp_w <= pwdata[adbsm_pkg::REG_W-1:0];
      else vp_h <= pwdata[adbsm_pkg::REG_W-1:0];
    end
  end

  // event transactions: update drag state and predict
  always @(posedge clk) begin
    drag_pair_t p;
    if (rst) begin
      dragging <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
    end else if (in_valid && !in_stall && operation != adbsm_pkg::OP_IGNORED) begin
      if (operation == adbsm_pkg::OP_MOVE) begin
        if (dragging && (cursor_x != prev_x || cursor_y != prev_y)) begin
          {p.fx, p.fy, p.fz} = sphere_of(prev_x, prev_y);
          {p.tx, p.ty, p.tz} = sphere_of(cursor_x, cursor_y);
          pair_q.push_back(p);
        end
      end else if (operation == adbsm_pkg::OP_PRESS) begin
        dragging <= (button == adbsm_pkg::BTN_RIGHT);
      end else begin
        dragging <= 1'b0;
      end
      prev_x <= cursor_x;
      prev_y <= cursor_y;
    end
  end

  // result transactions
  initial errors = 0;
  always @(posedge clk) begin
    drag_pair_t e, a;
    if (!rst && out_valid && !out_stall) begin
      a = '{from_x, from_y, from_z, to_x, to_y, to_z};
      if (pair_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", a);
      end else begin
        e = pair_q.pop_front();
        if (e != a) begin
          errors++;
          if (errors <= 10)
            $display("mismatch from %h %h %h to %h %h %h, expected %h %h %h to %h %h %h",
                     a.fx, a.fy, a.fz, a.tx, a.ty, a.tz,
                     e.fx, e.fy, e.fz, e.tx, e.ty, e.tz);
        end
      end
    end
  end
endmodule

// File: dv/tb_top.sv
// tb_top: stimulus, register writes and verdict for the arcball drag sphere mapper
// depends on adbsm_pkg, arcball_drag_sphere_mapper and adbsm_checker
module tb_top;

  localparam int LIMIT = 4000000;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [adbsm_pkg::APB_AW-1:0] paddr = '0;
  logic [adbsm_pkg::APB_DW-1:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] operation = '0, button = '0;
  logic signed [13:0] cursor_x = '0, cursor_y = '0;
  logic signed [15:0] from_x, from_y, to_x, to_y;
  logic [14:0] from_z, to_z;
  int errors, pending, cycles = 0;
  bit calm = 0;

  always #2 clk = ~clk;

  arcball_drag_sphere_mapper dut (.*);
  adbsm_checker chk (.*);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side stall
  always @(posedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);

  task automatic reg_write(logic idx, int val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // one event transaction, with a random idle gap first unless calm is set
  task automatic send_event(logic [1:0] op, logic [1:0] btn, int x, int y);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1; operation <= op; button <= btn;
    cursor_x <= 14'(x); cursor_y <= 14'(y);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // a drag: right press, then several moves mostly near the viewport
  task automatic drag_gesture(int w, int h);
    int n;
    send_event(adbsm_pkg::OP_PRESS, adbsm_pkg::BTN_RIGHT, $urandom_range(w),
               $urandom_range(h));
    n = $urandom_range(2, 8);
    repeat (n) begin
      if ($urandom_range(9) < 8)
        send_event(adbsm_pkg::OP_MOVE, 2'($urandom), $urandom_range(w + 2) - 1,
                   $urandom_range(h + 2) - 1);
      else
        send_event(adbsm_pkg::OP_MOVE, 2'($urandom), $signed(14'($urandom)),
                   $signed(14'($urandom)));
    end
  endtask

  initial begin
    int sent, w, h;
    int ws[6] = '{640, 1, 4096, 8191, 0, 37};
    int hs[6] = '{480, 4096, 1, 8191, 0, 23};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset viewport
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, 5, 5);
    send_event(adbsm_pkg::OP_PRESS, adbsm_pkg::BTN_RIGHT, 320, 240);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, 320, 240);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_UNKNOWN, 0, 0);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, 639, 479);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, 8191, -8192);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, -8192, 8191);
    send_event(adbsm_pkg::OP_IGNORED, adbsm_pkg::BTN_RIGHT, 1, 1);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, 100, 100);
    send_event(adbsm_pkg::OP_PRESS, adbsm_pkg::BTN_UNKNOWN, 10, 10);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, 20, 20);
    send_event(adbsm_pkg::OP_PRESS, adbsm_pkg::BTN_RIGHT, 0, 240);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_MIDDLE, 640, 240);
    send_event(adbsm_pkg::OP_RELEASE, adbsm_pkg::BTN_RIGHT, 1, 2);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_LEFT, 3, 4);
    send_event(adbsm_pkg::OP_PRESS, adbsm_pkg::BTN_LEFT, 1, 1);
    send_event(adbsm_pkg::OP_PRESS, adbsm_pkg::BTN_MIDDLE, 1, 1);
    send_event(adbsm_pkg::OP_PRESS, adbsm_pkg::BTN_RIGHT, 1, 1);
    send_event(adbsm_pkg::OP_MOVE, adbsm_pkg::BTN_RIGHT, 2, 1);
    drain();
    sent = 0;
    for (int ph = 0; ph < 12; ph++) begin
      w = (ph < 6) ? ws[ph] : $urandom_range(1, 4096);
      h = (ph < 6) ? hs[ph] : $urandom_range(1, 4096);
      reg_write(adbsm_pkg::REG_IDX_WIDTH, w);
      reg_write(adbsm_pkg::REG_IDX_HEIGHT, h);
      calm = (ph == 7);
      repeat (34) begin
        if ($urandom_range(9) < 7) drag_gesture(w, h);
        else send_event(2'($urandom), 2'($urandom), $signed(14'($urandom)),
                        $signed(14'($urandom)));
      end
      calm = 0;
      drain();
    end
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
